### design/lbis_pkg.sv
// Shared types and constants for the LED brightness serial-bus sequencer.
package lbis_pkg;

  localparam int NUM_CH   = 5;
  localparam int LEVEL_W  = 16;
  localparam int BRIGHT_W = 8;
  localparam int ADDR_W   = 7;
  localparam int CH_IDX_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef logic [BRIGHT_W-1:0] bright_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  // Register select bit per channel, bit i for channel i
  localparam logic [NUM_CH-1:0] CH_REG_SEL = 5'b01011;

  // Configuration reset values
  localparam bright_t MIN_LEVEL_RST     = 8'd30;
  localparam bright_t MAX_LEVEL_RST     = 8'd255;
  localparam addr_t   FIRST_DEVICE_RST  = 7'h5C;
  localparam addr_t   SECOND_DEVICE_RST = 7'h5A;
  localparam addr_t   THIRD_DEVICE_RST  = 7'h58;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEVEL     = 3'd0,
    REG_MAX_LEVEL     = 3'd1,
    REG_FIRST_DEVICE  = 3'd2,
    REG_SECOND_DEVICE = 3'd3,
    REG_THIRD_DEVICE  = 3'd4
  } cfg_reg_t;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_CH0   = 3'd1,
    PH_CH1   = 3'd2,
    PH_CH2   = 3'd3,
    PH_CH3   = 3'd4,
    PH_CH4   = 3'd5,
    PH_STORE = 3'd6
  } phase_t;

  typedef struct packed {
    bright_t min_level;
    bright_t max_level;
    addr_t   first_device;
    addr_t   second_device;
    addr_t   third_device;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_0;
    logic [LEVEL_W-1:0] level_1;
    logic [LEVEL_W-1:0] level_2;
    logic [LEVEL_W-1:0] level_3;
    logic [LEVEL_W-1:0] level_4;
    logic               bus_idle;
  } in_beat_t;

  typedef struct packed {
    logic    send;
    addr_t   device_address;
    logic    register_select;
    bright_t brightness;
    logic    idle;
  } out_beat_t;

  // Sequencer status and lane write strobes
  typedef struct packed {
    logic waiting;
    logic issued;
    logic snap_we;
    logic cur_we;
  } seq_stat_t;

endpackage

### design/lbis_lane.sv
// One channel lane: clamp, change test, snapshot and current level registers.
module lbis_lane
  import lbis_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [LEVEL_W-1:0] level,
  input  bright_t            min_level,
  input  bright_t            max_level,
  input  logic               snap_we,
  input  logic               cur_we,
  output bright_t            snapshot,
  output logic               changed
);

  bright_t current;
  logic [LEVEL_W-1:0] upper;
  bright_t clamped;

  // Clamp down to max first, then up to min so min wins
  always_comb begin
    upper = (level > {{(LEVEL_W-BRIGHT_W){1'b0}}, max_level}) ?
            {{(LEVEL_W-BRIGHT_W){1'b0}}, max_level} : level;
    clamped = (upper < {{(LEVEL_W-BRIGHT_W){1'b0}}, min_level}) ?
              min_level : upper[BRIGHT_W-1:0];
  end

  assign changed = (clamped != current);

  // Snapshot holds no reset value; it is always written before use
  always_ff @(posedge clk) begin
    if (snap_we) begin
      snapshot <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current <= '0;
    end else if (cur_we) begin
      current <= snapshot;
    end
  end

endmodule

### design/lbis_seq.sv
// Merge of lane results and the write sequencer state machine.
module lbis_seq
  import lbis_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              bus_idle,
  input  logic [NUM_CH-1:0] changed,
  input  bright_t           snapshot [NUM_CH],
  input  cfg_t              cfg,
  output out_beat_t         result,
  output seq_stat_t         stat
);

  phase_t phase, phase_next;
  logic issued, issued_next;
  logic [CH_IDX_W-1:0] ch;
  addr_t ch_addr;

  // State registers advance once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_WAIT;
      issued <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      issued <= issued_next;
    end
  end

  // Channel served by the current write phase
  always_comb begin
    ch = CH_IDX_W'(phase - PH_CH0);
    case (phase)
      PH_CH0:  ch_addr = cfg.first_device;
      PH_CH1:  ch_addr = cfg.second_device;
      PH_CH2:  ch_addr = cfg.second_device;
      default: ch_addr = cfg.third_device;
    endcase
  end

  // Next state and result
  always_comb begin
    phase_next   = phase;
    issued_next  = issued;
    result       = '0;
    stat.waiting = 1'b0;
    stat.issued  = issued;
    stat.snap_we = 1'b0;
    stat.cur_we  = 1'b0;
    case (phase)
      PH_CH0, PH_CH1, PH_CH2, PH_CH3, PH_CH4: begin
        if (bus_idle) begin
          if (issued) begin
            issued_next = 1'b0;
            phase_next  = phase_t'(phase + 3'd1);
          end else begin
            issued_next            = 1'b1;
            result.send            = 1'b1;
            result.device_address  = ch_addr;
            result.register_select = CH_REG_SEL[ch];
            result.brightness      = snapshot[ch];
          end
        end
      end
      PH_STORE: begin
        stat.cur_we = accept;
        phase_next  = PH_WAIT;
      end
      default: begin
        stat.waiting = 1'b1;
        stat.snap_we = accept;
        result.idle  = 1'b1;
        phase_next   = (|changed) ? PH_CH0 : PH_WAIT;
      end
    endcase
  end

endmodule

### design/led_brightness_i2c_sequencer.sv
// Top level of the LED brightness serial-bus sequencer.
// Usage:
//   in_valid/in_stall/in_data carry one tick beat: five requested levels and a
//   bus idle flag. out_valid/out_stall/out_data carry exactly one result beat
//   per input beat: a write command (send, address, register, brightness)
//   and the idle flag. A beat moves when valid is high and stall is low.
//   cfg_write/cfg_index/cfg_data write a register: 0 min level,
//   1 max level, 2..4 device addresses; other indexes are ignored.
// Timing:
//   Five lanes clamp and compare all channels in parallel and the sequencer
//   steps in the same cycle, so a beat is taken every cycle while the output
//   is not held by out_stall, and its result is in the output register next cycle.
// Reset:
//   Sequencer returns to waiting, current levels clear to zero, the
//   configuration takes its default values, and the output register empties.
// Stall:
//   While the output beat is held by out_stall, in_stall is raised and no
//   new tick is taken; nothing is dropped.
module led_brightness_i2c_sequencer
  import lbis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic in_accept;
  logic [LEVEL_W-1:0] levels [NUM_CH];
  bright_t snapshot [NUM_CH];
  logic [NUM_CH-1:0] changed;
  out_beat_t result;
  seq_stat_t stat;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_level     <= MIN_LEVEL_RST;
      cfg.max_level     <= MAX_LEVEL_RST;
      cfg.first_device  <= FIRST_DEVICE_RST;
      cfg.second_device <= SECOND_DEVICE_RST;
      cfg.third_device  <= THIRD_DEVICE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_LEVEL:     cfg.min_level     <= cfg_data;
        REG_MAX_LEVEL:     cfg.max_level     <= cfg_data;
        REG_FIRST_DEVICE:  cfg.first_device  <= cfg_data[ADDR_W-1:0];
        REG_SECOND_DEVICE: cfg.second_device <= cfg_data[ADDR_W-1:0];
        REG_THIRD_DEVICE:  cfg.third_device  <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel levels into lane order
  assign levels[0] = in_data.level_0;
  assign levels[1] = in_data.level_1;
  assign levels[2] = in_data.level_2;
  assign levels[3] = in_data.level_3;
  assign levels[4] = in_data.level_4;

  // Per-channel lanes
  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    lbis_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .level     (levels[i]),
      .min_level (cfg.min_level),
      .max_level (cfg.max_level),
      .snap_we   (stat.snap_we),
      .cur_we    (stat.cur_we),
      .snapshot  (snapshot[i]),
      .changed   (changed[i])
    );
  end

  lbis_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_accept),
    .bus_idle (in_data.bus_idle),
    .changed  (changed),
    .snapshot (snapshot),
    .cfg      (cfg),
    .result   (result),
    .stat     (stat)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  // A beat taken while waiting yields an idle result with no write
  a_wait_result: assert property (@(posedge clk) disable iff (rst)
    in_accept && stat.waiting |=> out_valid && out_data.idle && !out_data.send)
    else $error("waiting beat did not give an idle result");

  // An issued write is always followed by the issued mark
  a_send_marks: assert property (@(posedge clk) disable iff (rst)
    in_accept && result.send |=> stat.issued)
    else $error("write issued without issued mark");

  // The input side only stalls behind a held output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output beat");

  // Snapshot and current level writes never coincide
  a_we_excl: assert property (@(posedge clk) disable iff (rst)
    !(stat.snap_we && stat.cur_we))
    else $error("snapshot and current written together");
`endif

endmodule

### verif/led_brightness_i2c_sequencer_tb.sv
// Self-checking testbench for the LED brightness serial-bus sequencer.
module led_brightness_i2c_sequencer_tb
  import lbis_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT      = 300000;  // cycle budget for the whole run
  localparam int LONG_HOLD  = 150;     // receiver hold-off, in cycles
  localparam int PHASE_TICKS = 200;
  localparam int NUM_PHASES  = 7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  led_brightness_i2c_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sequencer shadow state and register copy
  cfg_t    cfg_now = '{min_level: MIN_LEVEL_RST, max_level: MAX_LEVEL_RST,
                       first_device: FIRST_DEVICE_RST,
                       second_device: SECOND_DEVICE_RST,
                       third_device: THIRD_DEVICE_RST};
  phase_t  seq_phase = PH_WAIT;
  logic    seq_issued = 1'b0;
  bright_t snap_lvl [NUM_CH] = '{default: '0};
  bright_t cur_lvl  [NUM_CH] = '{default: '0};

  in_beat_t  tick_queue [$];
  out_beat_t expected_cmds [$];
  in_beat_t  last_req = '0;

  bit send_gaps = 1'b1;
  bit stall_gaps = 1'b1;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  int send_gap = 0;

  int errors = 0;
  int cycles = 0;
  int n_ticks = 0;
  int n_checked = 0;
  int n_held = 0;
  int n_seqs = 0;
  int n_unchanged = 0;
  int n_writes = 0;
  int n_busy = 0;

  // Gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bright_t limit_level(logic [LEVEL_W-1:0] raw);
    logic [LEVEL_W-1:0] v;
    v = raw;
    if (v > LEVEL_W'(cfg_now.max_level)) v = LEVEL_W'(cfg_now.max_level);
    if (v < LEVEL_W'(cfg_now.min_level)) v = LEVEL_W'(cfg_now.min_level);
    return v[BRIGHT_W-1:0];
  endfunction

  // One poll of the sequencer: advances the shadow state, returns the command beat
  function automatic out_beat_t sequence_tick(in_beat_t t);
    out_beat_t o;
    logic [LEVEL_W-1:0] lv [NUM_CH];
    bright_t c;
    logic changed;
    int ch;
    o = '0;
    changed = 1'b0;
    lv[0] = t.level_0;
    lv[1] = t.level_1;
    lv[2] = t.level_2;
    lv[3] = t.level_3;
    lv[4] = t.level_4;
    case (seq_phase)
      PH_CH0, PH_CH1, PH_CH2, PH_CH3, PH_CH4: begin
        ch = int'(seq_phase) - 1;
        if (!t.bus_idle) begin
          n_busy++;
        end else if (seq_issued) begin
          seq_issued = 1'b0;
          seq_phase = phase_t'(seq_phase + 3'd1);
        end else begin
          seq_issued = 1'b1;
          o.send = 1'b1;
          o.device_address = (ch == 0) ? cfg_now.first_device :
                             (ch <= 2) ? cfg_now.second_device : cfg_now.third_device;
          o.register_select = (ch == 2 || ch == 4) ? 1'b0 : 1'b1;
          o.brightness = snap_lvl[ch];
          n_writes++;
        end
      end
      PH_STORE: begin
        cur_lvl = snap_lvl;
        seq_phase = PH_WAIT;
      end
      default: begin
        // waiting: clamp, snapshot, and look for a change
        o.idle = 1'b1;
        for (ch = 0; ch < NUM_CH; ch++) begin
          c = limit_level(lv[ch]);
          if (c != cur_lvl[ch]) changed = 1'b1;
          snap_lvl[ch] = c;
        end
        seq_phase = changed ? PH_CH0 : PH_WAIT;
        if (changed) n_seqs++;
        else n_unchanged++;
      end
    endcase
    return o;
  endfunction

  // Driver: feeds ticks from the queue, predicts each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) n_held++;
      if (in_valid && !in_stall) begin
        expected_cmds.push_back(sequence_tick(in_data));
        n_ticks++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          in_data <= tick_queue.pop_front();
          in_valid <= 1'b1;
          send_gap = (send_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: requested long hold-offs first, then random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: each result beat against the oldest expectation
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected result beat %h, nothing expected", $time, out_data);
      end else begin
        want = expected_cmds.pop_front();
        n_checked++;
        if (out_data.send !== want.send ||
            out_data.device_address !== want.device_address ||
            out_data.register_select !== want.register_select ||
            out_data.brightness !== want.brightness ||
            out_data.idle !== want.idle) begin
          errors++;
          if (errors <= 50)
            $display("%0t: mismatch send %b/%b addr %h/%h reg %b/%b bright %h/%h idle %b/%b",
                     $time, want.send, out_data.send, want.device_address,
                     out_data.device_address, want.register_select,
                     out_data.register_select, want.brightness, out_data.brightness,
                     want.idle, out_data.idle);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_tick(int l0, int l1, int l2, int l3, int l4, bit bus);
    in_beat_t t;
    t.level_0 = LEVEL_W'(l0);
    t.level_1 = LEVEL_W'(l1);
    t.level_2 = LEVEL_W'(l2);
    t.level_3 = LEVEL_W'(l3);
    t.level_4 = LEVEL_W'(l4);
    t.bus_idle = bus;
    tick_queue.push_back(t);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    int v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom_range(0, 65535);
      2: v = $urandom_range(0, 255);
      3: v = int'(cfg_now.min_level) + $urandom_range(0, 2) - 1;
      4: v = int'(cfg_now.max_level) + $urandom_range(0, 2) - 1;
      default: v = $urandom_range(0, 1) ? 65535 : 0;
    endcase
    if (v < 0) v = 0;
    return v[LEVEL_W-1:0];
  endfunction

  // Mostly repeats the last request; now and then some channels move
  task automatic add_random_tick();
    in_beat_t t;
    t = last_req;
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1)) t.level_0 = pick_level();
      if ($urandom_range(0, 1)) t.level_1 = pick_level();
      if ($urandom_range(0, 1)) t.level_2 = pick_level();
      if ($urandom_range(0, 1)) t.level_3 = pick_level();
      if ($urandom_range(0, 1)) t.level_4 = pick_level();
    end
    t.bus_idle = ($urandom_range(0, 3) != 0);
    last_req = t;
    tick_queue.push_back(t);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    case (r)
      REG_MIN_LEVEL:     cfg_now.min_level = v;
      REG_MAX_LEVEL:     cfg_now.max_level = v;
      REG_FIRST_DEVICE:  cfg_now.first_device = v[ADDR_W-1:0];
      REG_SECOND_DEVICE: cfg_now.second_device = v[ADDR_W-1:0];
      REG_THIRD_DEVICE:  cfg_now.third_device = v[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int p);
    case (p)
      1: ;  // reset values
      2: begin
        write_reg(REG_MIN_LEVEL, 8'd0);
        write_reg(REG_MAX_LEVEL, 8'd255);
        write_reg(REG_FIRST_DEVICE, 8'd0);
        write_reg(REG_SECOND_DEVICE, 8'd127);
        write_reg(REG_THIRD_DEVICE, 8'h55);
      end
      3: begin
        // min above max: min wins
        write_reg(REG_MIN_LEVEL, 8'd200);
        write_reg(REG_MAX_LEVEL, 8'd100);
        write_reg(REG_FIRST_DEVICE, 8'd127);
        write_reg(REG_SECOND_DEVICE, 8'd0);
        write_reg(REG_THIRD_DEVICE, 8'd127);
      end
      4: begin
        write_reg(REG_MIN_LEVEL, 8'd255);
        write_reg(REG_MAX_LEVEL, 8'd0);
      end
      5: begin
        write_reg(REG_MIN_LEVEL, 8'd128);
        write_reg(REG_MAX_LEVEL, 8'd128);
        write_reg(REG_FIRST_DEVICE, 8'h5C);
      end
      default: begin
        // random settings; upper data bit set now and then on addresses
        write_reg(REG_MIN_LEVEL, 8'($urandom_range(0, 120)));
        write_reg(REG_MAX_LEVEL, 8'($urandom_range(100, 255)));
        write_reg(REG_FIRST_DEVICE, 8'($urandom));
        write_reg(REG_SECOND_DEVICE, 8'($urandom));
        write_reg(REG_THIRD_DEVICE, 8'($urandom));
      end
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every tick is taken and every result beat has come back
  task automatic drain();
    @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || expected_cmds.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: first update from zero with busy ticks inside the sequence
    add_tick(0, 0, 0, 0, 0, 1'b1);
    add_tick(0, 0, 0, 0, 0, 1'b0);
    add_tick(0, 0, 0, 0, 0, 1'b1);
    add_tick(0, 0, 0, 0, 0, 1'b0);
    repeat (10) add_tick(65535, 65535, 65535, 65535, 65535, 1'b1);
    // raw levels differ but clamp to the stored ones: no sequence
    add_tick(5, 10, 29, 0, 30, 1'b0);
    // top of range, just over max, just under and over min
    add_tick(65535, 256, 255, 29, 31, 1'b0);
    repeat (11) add_tick(0, 0, 0, 0, 0, 1'b1);
    drain();

    for (int p = 1; p <= NUM_PHASES; p++) begin
      send_gaps = (p != 2 && p != 5);
      stall_gaps = (p != 2 && p != 4);
      set_regs(p);
      repeat (PHASE_TICKS) add_random_tick();
      if (p == 2) holds_asked++;
      drain();
    end

    repeat (5) @(posedge clk);
    $display("Checked %0d result beats from %0d ticks over %0d register settings.",
             n_checked, n_ticks, NUM_PHASES);
    $display("Sequences %0d, unchanged polls %0d, writes %0d, busy-bus holds %0d, %0d %s",
             n_seqs, n_unchanged, n_writes, n_busy, n_held, "cycles of input back-pressure.");
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
design/lbis_pkg.sv
design/lbis_lane.sv
design/lbis_seq.sv
design/led_brightness_i2c_sequencer.sv
verif/led_brightness_i2c_sequencer_tb.sv
